// ===== sv/ray_plane_projection_macros.svh =====
// Assertion macros for the ray plane projection block.
// Included by ray_plane_projection, the module that carries concurrent checks.
`ifndef RAY_PLANE_PROJECTION_MACROS_SVH
`define RAY_PLANE_PROJECTION_MACROS_SVH
`ifndef ASSERT_OFF
`define RPP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: lbl");
`define RPP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: lbl");
`else
`define RPP_ASSERT(lbl, clk, rst_n, prop)
`define RPP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== sv/rpp_pkg.sv =====
// Package for the ray plane projection block: widths and shared types.
// No dependencies.
package rpp_pkg;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned FracBitsD = 16;
  localparam int unsigned SumW      = 68;   // exact dot-product sum width
  localparam int unsigned MagW      = 64;   // magnitude of a dot product
  localparam int unsigned QuoW      = 34;   // quotient capped at 2^33
  localparam int unsigned InDataW   = 320;
  localparam int unsigned OutDataW  = 104;

  // Flags that ride along the divider pipeline
  typedef struct packed {
    logic nneg;
    logic dneg;
    logic nzero;
    logic dzero;
  } rpp_sign_t;
endpackage

// ===== sv/rpp_dot.sv =====
// Dot-product front end: numerator and denominator magnitudes, two stages.
// Depends on rpp_pkg.
module rpp_dot (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rpp_pkg::InDataW-1:0]   data_i,
  output logic                          valid_o,
  output logic [rpp_pkg::MagW-1:0]      nmag_o,
  output logic [rpp_pkg::MagW-1:0]      dmag_o,
  output rpp_pkg::rpp_sign_t            sign_o,
  output logic [3*rpp_pkg::CoordW-1:0]  pt_o,
  output logic [3*rpp_pkg::CoordW-1:0]  dir_o
);
  import rpp_pkg::*;
  parameter int unsigned FRAC_BITS = FracBitsD;

  logic signed [CoordW-1:0] a, b, c, d;
  logic signed [2*CoordW-1:0] prod_d [6];
  logic signed [2*CoordW-1:0] prod_q [6];
  logic signed [SumW-1:0] dcon_d, dcon_q;
  logic [3*CoordW-1:0] pt_q, dir_q;
  logic v1_q;
  logic signed [SumW-1:0] sn, sd;
  logic [SumW-1:0] nm, dm;

  assign a = data_i[0*CoordW +: CoordW];
  assign b = data_i[1*CoordW +: CoordW];
  assign c = data_i[2*CoordW +: CoordW];
  assign d = data_i[3*CoordW +: CoordW];

  // Stage 1: six 32x32 products
  always_comb begin
    prod_d[0] = a * $signed(data_i[4*CoordW +: CoordW]);
    prod_d[1] = b * $signed(data_i[5*CoordW +: CoordW]);
    prod_d[2] = c * $signed(data_i[6*CoordW +: CoordW]);
    prod_d[3] = a * $signed(data_i[7*CoordW +: CoordW]);
    prod_d[4] = b * $signed(data_i[8*CoordW +: CoordW]);
    prod_d[5] = c * $signed(data_i[9*CoordW +: CoordW]);
    dcon_d    = SumW'(d) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      dcon_q <= dcon_d;
      pt_q   <= data_i[4*CoordW +: 3*CoordW];
      dir_q  <= data_i[7*CoordW +: 3*CoordW];
    end
  end

  // Stage 2: sums, sign and magnitude
  always_comb begin
    sn = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + dcon_q;
    sd = SumW'(prod_q[3]) + SumW'(prod_q[4]) + SumW'(prod_q[5]);
    nm = sn[SumW-1] ? (~sn + 1'b1) : sn;
    dm = sd[SumW-1] ? (~sd + 1'b1) : sd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_o      <= nm[MagW-1:0];
      dmag_o      <= dm[MagW-1:0];
      sign_o.nneg <= !sn[SumW-1] && (sn != '0);
      sign_o.dneg <= sd[SumW-1];
      sign_o.nzero <= (sn == '0);
      sign_o.dzero <= (sd == '0);
      pt_o        <= pt_q;
      dir_o       <= dir_q;
    end
  end
endmodule

// ===== sv/rpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
// Depends on rpp_pkg.
module rpp_div #(
  parameter int unsigned FRAC_BITS = rpp_pkg::FracBitsD,
  parameter int unsigned SideW     = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rpp_pkg::MagW-1:0]   nmag_i,
  input  logic [rpp_pkg::MagW-1:0]   dmag_i,
  input  logic [SideW-1:0]           side_i,
  output logic                       valid_o,
  output logic [rpp_pkg::QuoW-1:0]   quo_o,
  output logic [SideW-1:0]           side_o
);
  import rpp_pkg::*;
  localparam int unsigned DivW  = MagW + FRAC_BITS;  // dividend bits
  localparam int unsigned Steps = DivW;

  // per stage registers
  logic [DivW-1:0]  dvd_q  [Steps+1];
  logic [MagW:0]    rem_q  [Steps+1];
  logic [MagW-1:0]  dsr_q  [Steps+1];
  logic [QuoW-1:0]  quo_q  [Steps+1];
  logic [SideW-1:0] side_q [Steps+1];
  logic [Steps:0]   vld_q;

  always_comb begin
    dvd_q[0]  = {nmag_i, {FRAC_BITS{1'b0}}};
    rem_q[0]  = '0;
    dsr_q[0]  = dmag_i;
    quo_q[0]  = '0;
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [MagW+1:0] sh;
    logic            ge;
    logic [MagW+1:0] sub;
    logic [QuoW:0]   qn;
    always_comb begin
      sh  = {rem_q[s], dvd_q[s][DivW-1]};
      ge  = (sh >= {2'b00, dsr_q[s]});
      sub = sh - {2'b00, dsr_q[s]};
      qn  = {quo_q[s], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[s+1]  <= dvd_q[s] << 1;
        rem_q[s+1]  <= ge ? sub[MagW:0] : sh[MagW:0];
        dsr_q[s+1]  <= dsr_q[s];
        quo_q[s+1]  <= (qn[QuoW:QuoW-1] != 2'b00) ? {1'b1, {(QuoW-1){1'b0}}} : qn[QuoW-1:0];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = quo_q[Steps];
  assign side_o  = side_q[Steps];
endmodule

// ===== sv/rpp_hit.sv =====
// Back end: signed t with clamp, three products, floor, add and clamp.
// Depends on rpp_pkg.
module rpp_hit #(
  parameter int unsigned FRAC_BITS = rpp_pkg::FracBitsD
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rpp_pkg::QuoW-1:0]      quo_i,
  input  rpp_pkg::rpp_sign_t            sign_i,
  input  logic [3*rpp_pkg::CoordW-1:0]  pt_i,
  input  logic [3*rpp_pkg::CoordW-1:0]  dir_i,
  output logic                          valid_o,
  output logic [rpp_pkg::OutDataW-1:0]  data_o
);
  import rpp_pkg::*;

  // Stage A: sign and clamp t
  logic neg;
  logic signed [CoordW-1:0] t_d, t_q;
  logic tsat_d, tsat_q, va_q, fac_q, par_q;
  logic [3*CoordW-1:0] pa_q, da_q;

  always_comb begin
    neg    = sign_i.nneg != sign_i.dneg;
    tsat_d = 1'b0;
    if (!neg) begin
      if (quo_i > QuoW'(32'h7FFF_FFFF)) begin
        t_d = 32'h7FFF_FFFF; tsat_d = 1'b1;
      end else begin
        t_d = quo_i[CoordW-1:0];
      end
    end else begin
      if (quo_i > QuoW'(32'h8000_0000)) begin
        t_d = 32'h8000_0000; tsat_d = 1'b1;
      end else begin
        t_d = CoordW'(~quo_i + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      tsat_q <= tsat_d;
      fac_q  <= !sign_i.nzero && !neg;
      par_q  <= sign_i.dzero;
      pa_q   <= pt_i;
      da_q   <= dir_i;
    end
  end

  // Stage B: t times each direction component
  logic signed [2*CoordW-1:0] prd_q [3];
  logic vb_q, tsatb_q, facb_q, parb_q;
  logic [3*CoordW-1:0] pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prd_q[k] <= t_q * $signed(da_q[k*CoordW +: CoordW]);
      end
      tsatb_q <= tsat_q;
      facb_q  <= fac_q;
      parb_q  <= par_q;
      pb_q    <= pa_q;
    end
  end

  // Stage C: floor shift, add, clamp, pack
  logic signed [2*CoordW:0] h [3];
  logic [CoordW-1:0] hc [3];
  logic sat;

  always_comb begin
    sat = tsatb_q;
    for (int k = 0; k < 3; k++) begin
      h[k] = (2*CoordW+1)'($signed(pb_q[k*CoordW +: CoordW]))
           + (2*CoordW+1)'(prd_q[k] >>> FRAC_BITS);
      if (h[k] > $signed((2*CoordW+1)'(32'h7FFF_FFFF))) begin
        hc[k] = 32'h7FFF_FFFF; sat = 1'b1;
      end else if (h[k] < -$signed((2*CoordW+1)'(33'h0_8000_0000))) begin
        hc[k] = 32'h8000_0000; sat = 1'b1;
      end else begin
        hc[k] = h[k][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vb_q;
    end
  end

  // Field order: facing, hit_x, hit_y, hit_z, parallel, saturated
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (parb_q) begin
        data_o <= {5'b00000, 1'b0, 1'b1, {(3*CoordW){1'b0}}, 1'b0};
      end else begin
        data_o <= {5'b00000, sat, 1'b0, hc[2], hc[1], hc[0], facb_q};
      end
    end
  end
endmodule

// ===== sv/ray_plane_projection.sv =====
// Ray plane projection: t = -(A.p + D)/(A.d), hit = p + t*d, Q16.16 saturating.
// Data path from input transaction to result: rpp_dot, then rpp_div, then rpp_hit, each registered.
// Throughput: one transaction per cycle while the output is not stalled; the divider is fully pipelined.
// A stall on the output freezes the whole pipeline; no item is lost.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// Depends on rpp_pkg, rpp_dot, rpp_div, rpp_hit and the assertion macros.
`include "ray_plane_projection_macros.svh"
module ray_plane_projection #(
  parameter int unsigned FRAC_BITS = rpp_pkg::FracBitsD
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // plane_a, plane_b, plane_c, plane_d, point_x, point_y, point_z, dir_x, dir_y, dir_z
  input  logic [rpp_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // facing, hit_x, hit_y, hit_z, parallel, saturated, 5 zero bits
  output logic [rpp_pkg::OutDataW-1:0]  m_axis_tdata
);
  import rpp_pkg::*;
  localparam int unsigned SideW = $bits(rpp_sign_t) + 6*CoordW;

  logic en;
  logic dv;
  logic [MagW-1:0] nmag, dmag;
  rpp_sign_t sgn, sgn_q;
  logic [3*CoordW-1:0] pt, dir, pt_q, dir_q;
  logic qv;
  logic [QuoW-1:0] quo;

  // Pipeline advances when the output register is empty or being drained
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rpp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .data_i(s_axis_tdata),
    .valid_o(dv), .nmag_o(nmag), .dmag_o(dmag), .sign_o(sgn), .pt_o(pt), .dir_o(dir)
  );

  rpp_div #(.FRAC_BITS(FRAC_BITS), .SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .nmag_i(nmag), .dmag_i(dmag),
    .side_i({sgn, pt, dir}), .valid_o(qv), .quo_o(quo), .side_o({sgn_q, pt_q, dir_q})
  );

  rpp_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
    .clk_i, .rst_ni, .en_i(en), .valid_i(qv), .quo_i(quo), .sign_i(sgn_q),
    .pt_i(pt_q), .dir_i(dir_q), .valid_o(m_axis_tvalid), .data_o(m_axis_tdata)
  );

  // A parallel result never reports facing, saturation or a nonzero point
  `RPP_ASSERT(a_par_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[97]) |-> (m_axis_tdata[96:0] == '0 && !m_axis_tdata[98]))
  // Stalled output holds its payload
  `RPP_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
  // Input is ready whenever the output is free
  `RPP_ASSERT(a_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  // Quotient never exceeds its cap
  `RPP_ASSERT(a_cap, clk_i, rst_ni, qv |-> (quo <= {1'b1, {(QuoW-1){1'b0}}}))
endmodule

// ===== tb/ray_plane_projection_checker.sv =====
// Checker for ray_plane_projection: watches both stream channels, predicts each
// result from the accepted input transaction and compares it field by field.
// Depends on rpp_pkg for the channel widths.
module ray_plane_projection_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [rpp_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [rpp_pkg::OutDataW-1:0] m_axis_tdata,
  output int                           fail_count_o,
  output int                           pending_o
);
  localparam int Frac = rpp_pkg::FracBitsD;

  typedef struct packed {
    logic        saturated;
    logic        parallel;
    logic [31:0] hit_z;
    logic [31:0] hit_y;
    logic [31:0] hit_x;
    logic        facing;
  } hit_t;

  hit_t hit_queue[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = hit_queue.size();

  // Clamp a wide signed value to 32 bits
  function automatic logic [31:0] clamp32(logic signed [95:0] v, inout logic sat);
    if (v > 96'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -96'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact projection of the point along the direction onto the plane
  function automatic hit_t project(logic [rpp_pkg::InDataW-1:0] x);
    logic signed [95:0] f [10];
    logic signed [95:0] sn, sd, tq, h;
    logic [95:0]        nm, dm;
    logic [127:0]       q;
    logic [31:0]        hv [3];
    logic               nneg, dneg, neg, sat;
    hit_t               r;
    for (int i = 0; i < 10; i++) f[i] = $signed(x[32*i +: 32]);
    sn = -(f[0] * f[4] + f[1] * f[5] + f[2] * f[6] + (f[3] <<< Frac));
    sd = f[0] * f[7] + f[1] * f[8] + f[2] * f[9];
    r = '0;
    if (sd == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    nneg = sn < 0;
    dneg = sd < 0;
    nm   = nneg ? -sn : sn;
    dm   = dneg ? -sd : sd;
    q    = ({32'b0, nm} << Frac) / {32'b0, dm};
    neg  = nneg != dneg;
    sat  = 1'b0;
    if (!neg && q > 128'h7FFF_FFFF) begin
      q   = 128'h7FFF_FFFF;
      sat = 1'b1;
    end else if (neg && q > 128'h8000_0000) begin
      q   = 128'h8000_0000;
      sat = 1'b1;
    end
    tq = $signed({63'b0, q[32:0]});
    if (neg) tq = -tq;
    for (int i = 0; i < 3; i++) begin
      h     = f[4+i] + ((tq * f[7+i]) >>> Frac);
      hv[i] = clamp32(h, sat);
    end
    r.facing    = (nm != 0) && !neg;
    r.hit_x     = hv[0];
    r.hit_y     = hv[1];
    r.hit_z     = hv[2];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    fails++;
  endtask

  // Push predictions on input transactions, compare on output transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    hit_t got, want;
    if (!rst_ni) begin
      fails = 0;
      hit_queue.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) hit_queue.push_back(project(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[98:0];
        if (hit_queue.size() == 0) begin
          report("unexpected result", m_axis_tdata[31:0], 0);
        end else begin
          want = hit_queue.pop_front();
          if (got.facing != want.facing) report("facing", got.facing, want.facing);
          if (got.hit_x != want.hit_x) report("hit_x", got.hit_x, want.hit_x);
          if (got.hit_y != want.hit_y) report("hit_y", got.hit_y, want.hit_y);
          if (got.hit_z != want.hit_z) report("hit_z", got.hit_z, want.hit_z);
          if (got.parallel != want.parallel) report("parallel", got.parallel, want.parallel);
          if (got.saturated != want.saturated)
            report("saturated", got.saturated, want.saturated);
          if (m_axis_tdata[103:99] != '0) report("pad bits", m_axis_tdata[103:99], 0);
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for ray_plane_projection: clock, reset, directed and random
// query stimulus, output back-pressure and the verdict.
// Depends on rpp_pkg, the block and ray_plane_projection_checker.
module tb;
  localparam int NumRandom = 500;
  localparam int Latency   = 2 + 64 + 16 + 3;
  localparam logic [31:0] One = 32'h0001_0000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // plane_a, plane_b, plane_c, plane_d, point_x, point_y, point_z, dir_x, dir_y, dir_z
  logic [rpp_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // facing, hit_x, hit_y, hit_z, parallel, saturated, 5 zero bits
  logic [rpp_pkg::OutDataW-1:0] m_axis_tdata;
  int                           fail_count, pending;
  logic                         calm = 1'b0;
  logic                         hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  ray_plane_projection DUT (.*);

  ray_plane_projection_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one query and hold it until the transaction completes
  task automatic send_query(logic [31:0] a, b, c, d, px, py, pz, dx, dy, dz);
    logic rdy;
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dz, dy, dx, pz, py, px, d, c, b, a};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // Random coordinate: full range sometimes, small values mostly
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65535 * 16)) - 65535 * 8);
      2: return 32'($signed($urandom_range(200)) - 100) << 16;
      default: return 32'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // Receiver: random hold-off bursts, one long stall, none near the end
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && pending > 20) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (!calm && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [31:0] v [10];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Plane z = 0 hit from above, straight down
    send_query(0, 0, One, 0, One, 2 * One, 5 * One, 0, 0, -One);
    // Direction pointing away: negative t
    send_query(0, 0, One, 0, One, 2 * One, 5 * One, 0, 0, One);
    // Parallel direction: zero denominator
    send_query(0, 0, One, 0, One, One, One, One, One, 0);
    // All zero: zero numerator over zero denominator
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Point on the plane: zero numerator, t is zero
    send_query(0, One, 0, 0, 3 * One, 0, One, One, One, One);
    // Tiny t that truncates to zero but still faces the plane
    send_query(0, 0, One, 0, 0, 0, 1, 0, 0, -32'h7FFF_FFFF);
    // Huge t: quotient saturates
    send_query(0, 0, One, 32'h8000_0000, 0, 0, 0, 0, 0, 1);
    send_query(0, 0, One, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1);
    // Coordinates clamp
    send_query(0, 0, One, -(100 * One), 32'h7FFF_0000, 32'h8000_0000, 0,
               100 * One, -(100 * One), One);
    // Extremes of every field
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // Negative t with a floor on negative terms
    send_query(One, 0, 0, -(3 * One), 0, 7, 0, -One, 3, -5);
    // Random queries; the last stretch runs without idling
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 60) calm = 1'b1;
      for (int k = 0; k < 10; k++) v[k] = rand_coord();
      if ($urandom_range(15) == 0) begin
        v[7] = 0;
        v[8] = 0;
        v[9] = 0;
      end
      send_query(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9]);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
